@@ src/jfss_pkg.sv @@
// Package with shared types, codes and marker classification for the JPEG frame size scanner.
`default_nettype none

package jfss_pkg;

  localparam logic [7:0] MarkerPrefix   = 8'hFF;
  localparam logic [7:0] MarkerSoi      = 8'hD8;
  localparam logic [7:0] MarkerSofFirst = 8'hC0;
  localparam logic [7:0] MarkerSofLast  = 8'hCF;
  localparam logic [7:0] MarkerDht      = 8'hC4;
  localparam logic [7:0] MarkerJpg      = 8'hC8;
  localparam logic [7:0] MarkerDac      = 8'hCC;
  localparam logic [7:0] MarkerTem      = 8'h01;
  localparam logic [7:0] MarkerRstFirst = 8'hD0;
  localparam logic [7:0] MarkerEoi      = 8'hD9;

  localparam logic [15:0] MinSegLen   = 16'd2;
  localparam logic [15:0] FrameHdrLen = 16'd6;
  localparam logic [2:0]  LastHdrIdx  = 3'd5;

  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_HUNT,
    PH_FILL,
    PH_LENHI,
    PH_LENLO,
    PH_SKIP,
    PH_HDR
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NOSTART  = 3'd1,
    ST_BADLEN   = 3'd2,
    ST_SHORTHDR = 3'd3,
    ST_ZEROSIZE = 3'd4,
    ST_TRUNC    = 3'd5
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  marker;
    logic [7:0]  len_hi;
    logic [15:0] skip_count;
    logic [2:0]  hdr_idx;
    logic [15:0] height;
    logic [15:0] width;
    logic        answer_given;
  } scan_state_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] width;
    logic [15:0] height;
  } result_t;

  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m inside {[MarkerSofFirst:MarkerSofLast]}) &&
           (m != MarkerDht) && (m != MarkerJpg) && (m != MarkerDac);
  endfunction

  function automatic logic is_lone_marker(input logic [7:0] m);
    return (m == MarkerTem) || (m inside {[MarkerRstFirst:MarkerEoi]});
  endfunction

endpackage

`default_nettype wire

@@ src/jfss_if.sv @@
// Stream interfaces for the byte input and the result output of the scanner.
`default_nettype none

interface jfss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface jfss_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] frame_width;
  logic [15:0] frame_height;

  modport source (output valid, status, frame_width, frame_height, input ready);
  modport sink   (input valid, status, frame_width, frame_height, output ready);
endinterface

`default_nettype wire

@@ src/jfss_step.sv @@
// Next-state and result logic of the scanner for one incoming byte.
`default_nettype none

module jfss_step
  import jfss_pkg::*;
(
  input  scan_state_t st_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output scan_state_t st_o,
  output logic        emit_o,
  output result_t     res_o
);

  scan_state_t cur;
  logic [15:0] seg_len;
  logic [15:0] payload_len;
  logic [15:0] skip_dec;
  logic        dec_emit;
  status_e     dec_status;

  // A byte marked first restarts the scan from the reset state.
  assign cur         = first_byte_i ? '0 : st_i;
  assign seg_len     = {cur.len_hi, data_byte_i};
  assign payload_len = seg_len - MinSegLen;
  assign skip_dec    = cur.skip_count - 16'd1;

  always_comb begin
    st_o       = cur;
    dec_emit   = 1'b0;
    dec_status = ST_FOUND;
    if (!cur.answer_given) begin
      case (cur.phase)
        PH_START0: begin
          if (data_byte_i != MarkerPrefix) begin
            dec_emit   = 1'b1;
            dec_status = ST_NOSTART;
          end else begin
            st_o.phase = PH_START1;
          end
        end
        PH_START1: begin
          if (data_byte_i != MarkerSoi) begin
            dec_emit   = 1'b1;
            dec_status = ST_NOSTART;
          end else begin
            st_o.phase = PH_HUNT;
          end
        end
        PH_HUNT: begin
          if (data_byte_i == MarkerPrefix) st_o.phase = PH_FILL;
        end
        PH_FILL: begin
          if (data_byte_i != MarkerPrefix) begin
            st_o.marker = data_byte_i;
            st_o.phase  = is_lone_marker(data_byte_i) ? PH_HUNT : PH_LENHI;
          end
        end
        PH_LENHI: begin
          st_o.len_hi = data_byte_i;
          st_o.phase  = PH_LENLO;
        end
        PH_LENLO: begin
          if (seg_len < MinSegLen) begin
            dec_emit   = 1'b1;
            dec_status = ST_BADLEN;
          end else if (is_frame_marker(cur.marker)) begin
            if (payload_len < FrameHdrLen) begin
              dec_emit   = 1'b1;
              dec_status = ST_SHORTHDR;
            end else begin
              st_o.hdr_idx = '0;
              st_o.height  = '0;
              st_o.width   = '0;
              st_o.phase   = PH_HDR;
            end
          end else if (payload_len == '0) begin
            st_o.phase = PH_HUNT;
          end else begin
            st_o.skip_count = payload_len;
            st_o.phase      = PH_SKIP;
          end
        end
        PH_SKIP: begin
          st_o.skip_count = skip_dec;
          if (skip_dec == '0) st_o.phase = PH_HUNT;
        end
        PH_HDR: begin
          case (cur.hdr_idx)
            3'd1:    st_o.height = {data_byte_i, 8'h00};
            3'd2:    st_o.height = {cur.height[15:8], data_byte_i};
            3'd3:    st_o.width  = {data_byte_i, 8'h00};
            3'd4:    st_o.width  = {cur.width[15:8], data_byte_i};
            default: ;
          endcase
          if (cur.hdr_idx >= LastHdrIdx) begin
            dec_emit   = 1'b1;
            dec_status = (cur.width == '0 || cur.height == '0) ? ST_ZEROSIZE : ST_FOUND;
          end else begin
            st_o.hdr_idx = cur.hdr_idx + 3'd1;
          end
        end
        default: st_o.phase = PH_HUNT;
      endcase
    end

    // A final byte that decides nothing by itself reports truncation.
    if (!cur.answer_given && !dec_emit && last_byte_i) begin
      dec_emit   = 1'b1;
      dec_status = ST_TRUNC;
    end
    if (dec_emit) st_o.answer_given = 1'b1;
  end

  assign emit_o       = dec_emit;
  assign res_o.status = dec_status;
  assign res_o.width  = (dec_status == ST_FOUND) ? cur.width  : '0;
  assign res_o.height = (dec_status == ST_FOUND) ? cur.height : '0;

endmodule

`default_nettype wire

@@ src/jpeg_frame_size_scanner_unit.sv @@
// Top level of the JPEG frame size scanner: byte stream in, one size result per file out.
// A result is registered and presented on the output in the cycle after the deciding byte is accepted.
// Throughput: one byte per cycle; the single output register is the only stall point.
// A byte is taken whenever the output register is empty or is being drained that cycle.
// Reset clears the scan state and empties the output register.
`default_nettype none

module jpeg_frame_size_scanner_unit
  import jfss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  jfss_in_if.sink           in_i,
  jfss_out_if.source        out_o
);

  scan_state_t st_q, st_d;
  logic        emit;
  result_t     res;
  logic        accept;
  logic        out_valid_q;
  result_t     out_res_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  jfss_step u_step (
    .st_i         (st_q),
    .data_byte_i  (in_i.data_byte),
    .first_byte_i (in_i.first_byte),
    .last_byte_i  (in_i.last_byte),
    .st_o         (st_d),
    .emit_o       (emit),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) st_q <= st_d;
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) out_res_q <= res;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_res_q.status;
  assign out_o.frame_width  = out_res_q.width;
  assign out_o.frame_height = out_res_q.height;

  a_quiet_after_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && st_q.answer_given && !in_i.first_byte |-> !emit)
    else $error("result produced after the answer for this file");

  a_answer_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |=> st_q.answer_given && out_valid_q)
    else $error("emitted result not registered");

  a_found_sizes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.status == ST_FOUND |->
      out_res_q.width != '0 && out_res_q.height != '0)
    else $error("found result with zero size");

  a_error_sizes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.status != ST_FOUND |->
      out_res_q.width == '0 && out_res_q.height == '0)
    else $error("error result with nonzero size");

endmodule

`default_nettype wire
